[hdl/pal_pkg.sv]
// Shared types and constants for the positional array list.
package pal_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CapW  = 6;
  localparam int unsigned PosW  = 5;
  localparam int unsigned ActW  = 2;

  localparam logic [CapW-1:0] CapReset = 6'd32;

  typedef enum logic [ActW-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_GET    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ADDR_POS     = 3'd0,
    ADDR_IDX     = 3'd1,
    ADDR_IDX_DEC = 3'd2,
    ADDR_IDX_INC = 3'd3,
    ADDR_ZERO    = 3'd4
  } addr_sel_e;

  typedef enum logic [1:0] {
    WDATA_VAL   = 2'd0,
    WDATA_RDATA = 2'd1,
    WDATA_ZERO  = 2'd2
  } wdata_sel_e;

  typedef enum logic [2:0] {
    IDX_HOLD = 3'd0,
    IDX_ZERO = 3'd1,
    IDX_POS  = 3'd2,
    IDX_TOP  = 3'd3,
    IDX_INC  = 3'd4,
    IDX_DEC  = 3'd5
  } idx_op_e;

  typedef struct packed {
    logic       req_load;
    logic       rd_en;
    addr_sel_e  rd_addr_sel;
    logic       wr_en;
    addr_sel_e  wr_addr_sel;
    wdata_sel_e wr_data_sel;
    idx_op_e    idx_op;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       res_clear;
    logic       res_acc_set;
    logic       res_found_set;
    logic       res_data_capture;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    ins_ok;
    logic    rem_ok;
    logic    get_ok;
    logic    cnt_zero;
    logic    rdata_nz;
    logic    idx_gt_pos;
    logic    idx_next_in_cap;
    logic    idx_next_in_cnt;
    logic    match;
    logic    clear_done;
  } status_t;

endpackage

[hdl/pal_datapath.sv]
// Datapath of the positional array list: entry memory, counters and result registers.
module pal_datapath #(
  parameter int unsigned SLOTS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pal_pkg::CapW-1:0]          cfg_capacity_i,
  input  logic [pal_pkg::ActW-1:0]          action_i,
  input  logic [pal_pkg::PosW-1:0]          position_i,
  input  logic signed [pal_pkg::DataW-1:0]  item_value_i,
  input  pal_pkg::cmd_t                     cmd_i,
  output pal_pkg::status_t                  sts_o,
  output logic signed [pal_pkg::DataW-1:0]  data_out_o,
  output logic                              accepted_o,
  output logic                              found_o
);

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [pal_pkg::CapW:0]   SlotsW  = (pal_pkg::CapW + 1)'(SLOTS);
  localparam logic [pal_pkg::CapW-1:0] LastIdx = pal_pkg::CapW'(SLOTS - 1);

  logic signed [pal_pkg::DataW-1:0] mem [SLOTS];
  logic signed [pal_pkg::DataW-1:0] rdata_q;
  logic signed [pal_pkg::DataW-1:0] wdata;

  logic [pal_pkg::CapW-1:0] capacity_q, capacity_d;
  logic [pal_pkg::CapW-1:0] count_q, count_d;
  logic [pal_pkg::CapW-1:0] idx_q, idx_d;

  pal_pkg::action_e                 act_q;
  logic [pal_pkg::PosW-1:0]         pos_q;
  logic signed [pal_pkg::DataW-1:0] val_q;

  logic signed [pal_pkg::DataW-1:0] res_data_q;
  logic                             res_acc_q;
  logic                             res_found_q;
  logic signed [pal_pkg::DataW-1:0] data_out_q;
  logic                             accepted_q;
  logic                             found_q;

  logic [pal_pkg::CapW-1:0] eff_cap;
  logic [pal_pkg::CapW-1:0] pos_ext;
  logic [pal_pkg::CapW-1:0] idx_inc;
  logic [pal_pkg::CapW-1:0] idx_dec;
  logic [pal_pkg::CapW:0]   idx_next_w;
  logic [pal_pkg::CapW-1:0] rd_addr;
  logic [pal_pkg::CapW-1:0] wr_addr;

  // A capacity above the store depth saturates to the depth.
  assign eff_cap    = ({1'b0, capacity_q} < SlotsW) ? capacity_q : SlotsW[pal_pkg::CapW-1:0];
  assign pos_ext    = {1'b0, pos_q};
  assign idx_inc    = idx_q + 1'b1;
  assign idx_dec    = idx_q - 1'b1;
  assign idx_next_w = {1'b0, idx_q} + 1'b1;

  always_comb begin
    unique case (cmd_i.rd_addr_sel)
      pal_pkg::ADDR_POS:     rd_addr = pos_ext;
      pal_pkg::ADDR_IDX:     rd_addr = idx_q;
      pal_pkg::ADDR_IDX_DEC: rd_addr = idx_dec;
      pal_pkg::ADDR_IDX_INC: rd_addr = idx_inc;
      default:               rd_addr = '0;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wr_addr_sel)
      pal_pkg::ADDR_POS:     wr_addr = pos_ext;
      pal_pkg::ADDR_IDX:     wr_addr = idx_q;
      pal_pkg::ADDR_IDX_DEC: wr_addr = idx_dec;
      pal_pkg::ADDR_IDX_INC: wr_addr = idx_inc;
      default:               wr_addr = '0;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wr_data_sel)
      pal_pkg::WDATA_VAL:   wdata = val_q;
      pal_pkg::WDATA_RDATA: wdata = rdata_q;
      default:              wdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr[AW-1:0]] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr[AW-1:0]];
    end
  end

  always_comb begin
    capacity_d = cfg_we_i ? cfg_capacity_i : capacity_q;
    count_d    = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - 1'b1;
    end
    unique case (cmd_i.idx_op)
      pal_pkg::IDX_ZERO: idx_d = '0;
      pal_pkg::IDX_POS:  idx_d = pos_ext;
      pal_pkg::IDX_TOP:  idx_d = eff_cap - 1'b1;
      pal_pkg::IDX_INC:  idx_d = idx_inc;
      pal_pkg::IDX_DEC:  idx_d = idx_dec;
      default:           idx_d = idx_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= pal_pkg::CapReset;
      count_q    <= '0;
      idx_q      <= '0;
    end else begin
      capacity_q <= capacity_d;
      count_q    <= count_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      act_q <= pal_pkg::action_e'(action_i);
      pos_q <= position_i;
      val_q <= item_value_i;
    end
    // A set in the same cycle as the clear wins.
    if (cmd_i.res_clear || cmd_i.res_data_capture) begin
      res_data_q <= cmd_i.res_data_capture ? rdata_q : '0;
    end
    if (cmd_i.res_clear || cmd_i.res_acc_set) begin
      res_acc_q <= cmd_i.res_acc_set;
    end
    if (cmd_i.res_clear || cmd_i.res_found_set) begin
      res_found_q <= cmd_i.res_found_set;
    end
    if (cmd_i.out_load) begin
      data_out_q <= res_data_q;
      accepted_q <= res_acc_q;
      found_q    <= res_found_q;
    end
  end

  assign sts_o.action          = act_q;
  assign sts_o.ins_ok          = (count_q < eff_cap) && (pos_ext < eff_cap);
  assign sts_o.rem_ok          = (count_q != '0) && (pos_ext < eff_cap);
  assign sts_o.get_ok          = pos_ext < count_q;
  assign sts_o.cnt_zero        = count_q == '0;
  assign sts_o.rdata_nz        = rdata_q != '0;
  assign sts_o.idx_gt_pos      = idx_q > pos_ext;
  assign sts_o.idx_next_in_cap = idx_next_w < {1'b0, eff_cap};
  assign sts_o.idx_next_in_cnt = idx_next_w < {1'b0, count_q};
  assign sts_o.match           = rdata_q == val_q;
  assign sts_o.clear_done      = idx_q == LastIdx;

  assign data_out_o = data_out_q;
  assign accepted_o = accepted_q;
  assign found_o    = found_q;

endmodule

[hdl/pal_controller.sv]
// Control state machine of the positional array list.
module pal_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  pal_pkg::status_t sts_i,
  output pal_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] StClear   = 4'd0;
  localparam logic [3:0] StIdle    = 4'd1;
  localparam logic [3:0] StStart   = 4'd2;
  localparam logic [3:0] StInsChk  = 4'd3;
  localparam logic [3:0] StUpRd    = 4'd4;
  localparam logic [3:0] StUpWr    = 4'd5;
  localparam logic [3:0] StRemData = 4'd6;
  localparam logic [3:0] StDnRd    = 4'd7;
  localparam logic [3:0] StDnWr    = 4'd8;
  localparam logic [3:0] StFindCmp = 4'd9;
  localparam logic [3:0] StGetData = 4'd10;
  localparam logic [3:0] StDone    = 4'd11;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{
      rd_addr_sel: pal_pkg::ADDR_POS,
      wr_addr_sel: pal_pkg::ADDR_POS,
      wr_data_sel: pal_pkg::WDATA_VAL,
      idx_op:      pal_pkg::IDX_HOLD,
      default:     1'b0
    };
    in_ready_o = 1'b0;

    unique case (state_q)
      StClear: begin
        cmd_o.wr_en       = 1'b1;
        cmd_o.wr_addr_sel = pal_pkg::ADDR_IDX;
        cmd_o.wr_data_sel = pal_pkg::WDATA_ZERO;
        if (sts_i.clear_done) begin
          cmd_o.idx_op = pal_pkg::IDX_ZERO;
          state_d      = StIdle;
        end else begin
          cmd_o.idx_op = pal_pkg::IDX_INC;
        end
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = StStart;
        end
      end
      StStart: begin
        cmd_o.res_clear = 1'b1;
        state_d         = StDone;
        unique case (sts_i.action)
          pal_pkg::ACT_INSERT: begin
            if (sts_i.ins_ok) begin
              cmd_o.rd_en = 1'b1;
              state_d     = StInsChk;
            end
          end
          pal_pkg::ACT_REMOVE: begin
            if (sts_i.rem_ok) begin
              cmd_o.rd_en = 1'b1;
              state_d     = StRemData;
            end
          end
          pal_pkg::ACT_FIND: begin
            cmd_o.res_acc_set = 1'b1;
            if (!sts_i.cnt_zero) begin
              cmd_o.rd_en       = 1'b1;
              cmd_o.rd_addr_sel = pal_pkg::ADDR_ZERO;
              cmd_o.idx_op      = pal_pkg::IDX_ZERO;
              state_d           = StFindCmp;
            end
          end
          default: begin
            if (sts_i.get_ok) begin
              cmd_o.rd_en = 1'b1;
              state_d     = StGetData;
            end
          end
        endcase
      end
      StInsChk: begin
        // An occupied slot makes room by moving the entries above it up by one.
        if (sts_i.rdata_nz) begin
          cmd_o.idx_op = pal_pkg::IDX_TOP;
          state_d      = StUpRd;
        end else begin
          cmd_o.wr_en       = 1'b1;
          cmd_o.cnt_inc     = 1'b1;
          cmd_o.res_acc_set = 1'b1;
          state_d           = StDone;
        end
      end
      StUpRd: begin
        if (sts_i.idx_gt_pos) begin
          cmd_o.rd_en       = 1'b1;
          cmd_o.rd_addr_sel = pal_pkg::ADDR_IDX_DEC;
          state_d           = StUpWr;
        end else begin
          cmd_o.wr_en       = 1'b1;
          cmd_o.cnt_inc     = 1'b1;
          cmd_o.res_acc_set = 1'b1;
          state_d           = StDone;
        end
      end
      StUpWr: begin
        cmd_o.wr_en       = 1'b1;
        cmd_o.wr_addr_sel = pal_pkg::ADDR_IDX;
        cmd_o.wr_data_sel = pal_pkg::WDATA_RDATA;
        cmd_o.idx_op      = pal_pkg::IDX_DEC;
        state_d           = StUpRd;
      end
      StRemData: begin
        cmd_o.res_data_capture = 1'b1;
        cmd_o.idx_op           = pal_pkg::IDX_POS;
        state_d                = StDnRd;
      end
      StDnRd: begin
        if (sts_i.idx_next_in_cap) begin
          cmd_o.rd_en       = 1'b1;
          cmd_o.rd_addr_sel = pal_pkg::ADDR_IDX_INC;
          state_d           = StDnWr;
        end else begin
          // The top slot of the capacity is emptied once the shift has reached it.
          cmd_o.wr_en       = 1'b1;
          cmd_o.wr_addr_sel = pal_pkg::ADDR_IDX;
          cmd_o.wr_data_sel = pal_pkg::WDATA_ZERO;
          cmd_o.cnt_dec     = 1'b1;
          cmd_o.res_acc_set = 1'b1;
          state_d           = StDone;
        end
      end
      StDnWr: begin
        cmd_o.wr_en       = 1'b1;
        cmd_o.wr_addr_sel = pal_pkg::ADDR_IDX;
        cmd_o.wr_data_sel = pal_pkg::WDATA_RDATA;
        cmd_o.idx_op      = pal_pkg::IDX_INC;
        state_d           = StDnRd;
      end
      StFindCmp: begin
        if (sts_i.match) begin
          cmd_o.res_found_set = 1'b1;
          state_d             = StDone;
        end else if (sts_i.idx_next_in_cnt) begin
          cmd_o.rd_en       = 1'b1;
          cmd_o.rd_addr_sel = pal_pkg::ADDR_IDX_INC;
          cmd_o.idx_op      = pal_pkg::IDX_INC;
        end else begin
          state_d = StDone;
        end
      end
      StGetData: begin
        cmd_o.res_data_capture = 1'b1;
        cmd_o.res_acc_set      = 1'b1;
        state_d                = StDone;
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hdl/positional_array_list.sv]
// A shifting insert or a remove takes longer for each moved entry, and a find for each entry
// compared; a get, an insert into a free slot, a refused request and a find on an empty list
// move no entries. A stalled result adds its wait. Requests are handled one at a time: the
// next request is taken in the idle state that follows the result load, and the entry memory
// has one read port and one write port. After reset a clearing pass writes zero to the first
// min(DEPTH, 64) slots of the store before the first request is taken.
module positional_array_list #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pal_pkg::CapW-1:0]          cfg_capacity_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [pal_pkg::ActW-1:0]          action_i,
  input  logic [pal_pkg::PosW-1:0]          position_i,
  input  logic signed [pal_pkg::DataW-1:0]  item_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [pal_pkg::DataW-1:0]  data_out_o,
  output logic                              accepted_o,
  output logic                              found_o
);

  // The capacity register cannot reach past slot 63, so only that many slots are stored.
  localparam int unsigned Slots = (DEPTH < 64) ? DEPTH : 64;

  pal_pkg::cmd_t    cmd;
  pal_pkg::status_t sts;

  assign cfg_ready_o = 1'b1;

  pal_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pal_datapath #(
    .SLOTS (Slots)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i),
    .cfg_capacity_i (cfg_capacity_i),
    .action_i       (action_i),
    .position_i     (position_i),
    .item_value_i   (item_value_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .data_out_o     (data_out_o),
    .accepted_o     (accepted_o),
    .found_o        (found_o)
  );

  // A request that is taken keeps the input closed on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready while a request is in progress");

  // A finished result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || out_ready_i))
    else $error("pending result overwritten");

  // Loading the output register always presents a result on the next cycle.
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> out_valid_o)
    else $error("loaded result not presented");

  // The count never moves both ways at once.
  a_count_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.cnt_inc && cmd.cnt_dec))
    else $error("count incremented and decremented together");

endmodule

[tb/positional_array_list_test.sv]
// Self-checking testbench for the positional array list, with request driver and result monitor.
module positional_array_list_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIST_DEPTH  = 32;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_REQS  = 115;

  typedef struct packed {
    pal_pkg::action_e                action;
    logic [pal_pkg::PosW-1:0]        position;
    logic signed [31:0]              value;
  } list_req_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic               acc;
    logic               fnd;
  } list_result_t;

  logic                              clk_i          = 1'b0;
  logic                              rst_ni         = 1'b0;
  logic                              cfg_valid_i    = 1'b0;
  logic                              cfg_ready_o;
  logic [pal_pkg::CapW-1:0]          cfg_capacity_i = '0;
  logic                              in_valid_i     = 1'b0;
  logic                              in_ready_o;
  logic [pal_pkg::ActW-1:0]          action_i       = '0;
  logic [pal_pkg::PosW-1:0]          position_i     = '0;
  logic signed [pal_pkg::DataW-1:0]  item_value_i   = '0;
  logic                              out_valid_o;
  logic                              out_ready_i    = 1'b0;
  logic signed [pal_pkg::DataW-1:0]  data_out_o;
  logic                              accepted_o;
  logic                              found_o;

  // Shadow copy of the list contents and the capacity register.
  logic [31:0]   list_slots [LIST_DEPTH];
  int unsigned   list_count = 0;
  int unsigned   list_cap   = 32'(pal_pkg::CapReset);

  list_req_t     req_backlog [$];
  list_result_t  owed_results [$];
  list_req_t     head_req;
  list_result_t  fresh_result;
  list_result_t  oldest_result;
  logic          req_taken  = 1'b0;
  logic          steady     = 1'b0;
  int unsigned   send_gap   = 0;
  int unsigned   recv_gap   = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   mismatches = 0;
  logic [5:0]    cap_plan [PHASES] = '{6'd0, 6'd1, 6'd2, 6'd63, 6'd33, 6'd32,
                                       6'd7, 6'd1, 6'd32, 6'd3, 6'd20, 6'd32};

  positional_array_list #(.DEPTH(LIST_DEPTH)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_capacity_i (cfg_capacity_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .position_i     (position_i),
    .item_value_i   (item_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_out_o     (data_out_o),
    .accepted_o     (accepted_o),
    .found_o        (found_o)
  );

  always #1 clk_i = ~clk_i;

  // Applies one request to the shadow list and returns the result it must produce.
  task automatic apply_list_request(input pal_pkg::action_e act,
                                    input logic [pal_pkg::PosW-1:0] pos,
                                    input logic [31:0] val, output list_result_t res);
    int unsigned eff;
    int unsigned p;
    int unsigned n;
    int          i;
    eff = (list_cap < LIST_DEPTH) ? list_cap : LIST_DEPTH;
    p   = 32'(pos);
    res = '0;
    case (act)
      pal_pkg::ACT_INSERT: begin
        if (list_count < eff && p < eff) begin
          // An occupied slot pushes everything above it up; the top entry falls off.
          if (list_slots[p] != 0) begin
            for (i = int'(eff) - 1; i > int'(p); i--) list_slots[i] = list_slots[i-1];
          end
          list_slots[p] = val;
          list_count++;
          res.acc = 1'b1;
        end
      end
      pal_pkg::ACT_REMOVE: begin
        if (list_count != 0 && p < eff) begin
          res.data = list_slots[p];
          for (i = int'(p); i + 1 < int'(eff); i++) list_slots[i] = list_slots[i+1];
          list_slots[eff-1] = '0;
          list_count--;
          res.acc = 1'b1;
        end
      end
      pal_pkg::ACT_FIND: begin
        n = (list_count < LIST_DEPTH) ? list_count : LIST_DEPTH;
        res.acc = 1'b1;
        for (i = 0; i < int'(n) && !res.fnd; i++) begin
          if (list_slots[i] == val) res.fnd = 1'b1;
        end
      end
      default: begin
        if (p < list_count && p < LIST_DEPTH) begin
          res.data = list_slots[p];
          res.acc  = 1'b1;
        end
      end
    endcase
  endtask

  task automatic add_req(input pal_pkg::action_e act, input logic [pal_pkg::PosW-1:0] pos,
                         input logic [31:0] val);
    list_req_t r;
    r.action   = act;
    r.position = pos;
    r.value    = val;
    req_backlog.push_back(r);
  endtask

  task automatic wait_list_idle();
    while (req_backlog.size() != 0 || in_valid_i || owed_results.size() != 0)
      @(negedge clk_i);
  endtask

  // Request driver and result-side back-pressure, both moved on the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || req_taken) begin
        if (send_gap != 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (!steady && $urandom_range(0, 5) == 0) begin
          send_gap   <= $urandom_range(0, 3);
          in_valid_i <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          head_req = req_backlog.pop_front();
          in_valid_i   <= 1'b1;
          action_i     <= head_req.action;
          position_i   <= head_req.position;
          item_value_i <= head_req.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end

      if (steady) begin
        out_ready_i <= 1'b1;
      end else if (recv_gap != 0) begin
        recv_gap    <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        recv_gap    <= $urandom_range(0, 3);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor: checks results first so a stray result cannot consume a fresh expectation.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid_i && in_ready_o;

      if (out_valid_o && out_ready_i) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result: data_out %0d accepted %0b found %0b",
                 data_out_o, accepted_o, found_o);
          mismatches++;
        end else begin
          oldest_result = owed_results.pop_front();
          if (data_out_o !== oldest_result.data) begin
            $error("data_out: expected %0d, got %0d", oldest_result.data, data_out_o);
            mismatches++;
          end
          if (accepted_o !== oldest_result.acc) begin
            $error("accepted: expected %0b, got %0b", oldest_result.acc, accepted_o);
            mismatches++;
          end
          if (found_o !== oldest_result.fnd) begin
            $error("found: expected %0b, got %0b", oldest_result.fnd, found_o);
            mismatches++;
          end
        end
      end

      if (in_valid_i && in_ready_o) begin
        apply_list_request(pal_pkg::action_e'(action_i), position_i, item_value_i,
                           fresh_result);
        owed_results.push_back(fresh_result);
      end

      if (cfg_valid_i && cfg_ready_o) list_cap = 32'(cfg_capacity_i);

      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("positional_array_list regression: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned                 k;
    int unsigned                 j;
    int unsigned                 eff;
    int unsigned                 span;
    int unsigned                 r;
    logic                        fill;
    pal_pkg::action_e            act;
    logic [pal_pkg::PosW-1:0]    pos;
    logic [31:0]                 val;
    logic [31:0]                 recent [$];

    for (k = 0; k < LIST_DEPTH; k++) list_slots[k] = '0;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests at the reset capacity.
    add_req(pal_pkg::ACT_GET,    5'd0,  32'd0);         // read from an empty list
    add_req(pal_pkg::ACT_REMOVE, 5'd0,  32'd0);         // remove from an empty list
    add_req(pal_pkg::ACT_FIND,   5'd0,  32'd0);         // search an empty list
    add_req(pal_pkg::ACT_INSERT, 5'd0,  32'h7FFF_FFFF);
    add_req(pal_pkg::ACT_INSERT, 5'd0,  32'h8000_0000); // occupied slot, shifts up
    add_req(pal_pkg::ACT_INSERT, 5'd31, 32'hFFFF_FFFF); // free top slot, no shift
    add_req(pal_pkg::ACT_FIND,   5'd0,  32'h8000_0000);
    add_req(pal_pkg::ACT_FIND,   5'd0,  32'd0);
    add_req(pal_pkg::ACT_FIND,   5'd0,  32'h1234_5678);
    add_req(pal_pkg::ACT_GET,    5'd1,  32'd0);
    add_req(pal_pkg::ACT_GET,    5'd31, 32'd0);         // beyond the count
    add_req(pal_pkg::ACT_INSERT, 5'd1,  32'd5);
    add_req(pal_pkg::ACT_INSERT, 5'd2,  32'd0);         // a zero value still counts as an entry
    add_req(pal_pkg::ACT_REMOVE, 5'd0,  32'd0);
    add_req(pal_pkg::ACT_REMOVE, 5'd31, 32'd0);         // top slot, nothing above it
    add_req(pal_pkg::ACT_FIND,   5'd0,  32'hFFFF_FFFF);
    add_req(pal_pkg::ACT_GET,    5'd0,  32'd0);
    add_req(pal_pkg::ACT_GET,    5'd2,  32'd0);
    add_req(pal_pkg::ACT_INSERT, 5'd30, 32'h0000_0001);
    add_req(pal_pkg::ACT_REMOVE, 5'd1,  32'd0);
    add_req(pal_pkg::ACT_FIND,   5'd0,  32'h7FFF_FFFF);

    for (k = 0; k < PHASES; k++) begin
      wait_list_idle();
      if (k >= PHASES - 2) steady <= 1'b1;

      @(negedge clk_i);
      cfg_valid_i    <= 1'b1;
      cfg_capacity_i <= cap_plan[k];
      @(posedge clk_i);
      while (!(cfg_valid_i && cfg_ready_o)) @(posedge clk_i);
      @(negedge clk_i);
      cfg_valid_i <= 1'b0;

      eff  = (32'(cap_plan[k]) > LIST_DEPTH) ? LIST_DEPTH : 32'(cap_plan[k]);
      span = (eff == 0) ? LIST_DEPTH : eff;
      // Alternate phases lean toward filling and toward draining the list.
      fill = (k % 2 == 0);

      for (j = 0; j < PHASE_REQS; j++) begin
        r = $urandom_range(0, 99);
        if (r < (fill ? 45 : 25)) act = pal_pkg::ACT_INSERT;
        else if (r < 60)          act = pal_pkg::ACT_REMOVE;
        else if (r < 80)          act = pal_pkg::ACT_FIND;
        else                      act = pal_pkg::ACT_GET;

        if ($urandom_range(0, 9) == 0) pos = pal_pkg::PosW'($urandom);
        else                           pos = pal_pkg::PosW'($urandom_range(0, span - 1));

        if (act == pal_pkg::ACT_FIND && recent.size() != 0 && $urandom_range(0, 1) == 1) begin
          val = recent[$urandom_range(0, recent.size() - 1)];
        end else begin
          case ($urandom_range(0, 11))
            0:       val = 32'd0;
            1:       val = 32'h7FFF_FFFF;
            2:       val = 32'h8000_0000;
            3:       val = 32'hFFFF_FFFF;
            4, 5:    val = $urandom_range(1, 9);
            default: val = $urandom;
          endcase
        end

        if (act == pal_pkg::ACT_INSERT) begin
          recent.push_back(val);
          if (recent.size() > 16) recent.delete(0);
        end
        add_req(act, pos, val);
      end
    end

    wait_list_idle();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("positional_array_list regression: pass");
    end else begin
      $display("positional_array_list regression: fail");
    end
    $finish;
  end

endmodule
